// File: design/brkbal_pkg.sv
// Shared types, constants and sizes for the bracket balance checker.
package brkbal_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int COUNT_BITS  = 16;
    localparam int LINE_BITS   = 16;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int STK_CW      = $clog2(STACK_DEPTH + 1);
    localparam longint LINE_OUT_MAX = 65535;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_STAR    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        MARK_OTHER       = 2'd0,
        MARK_OPEN_CURLY  = 2'd1,
        MARK_CLOSE_CURLY = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    typedef enum logic {
        REPORT_LINE  = 1'b0,
        REPORT_FINAL = 1'b1
    } t_report;

    typedef struct packed {
        logic                 report_kind;
        logic                 balanced;
        logic [LINE_BITS-1:0] line_number;
    } t_result;

endpackage

// File: design/brkbal_in_if.sv
// Input channel: one text byte or an end-of-text marker per word.
interface brkbal_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

// File: design/brkbal_out_if.sv
// Output channel: one line report or final verdict per word.
interface brkbal_out_if;
    import brkbal_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 report_kind;
    logic                 balanced;
    logic [LINE_BITS-1:0] line_number;

    modport source (output valid, output report_kind, output balanced,
                    output line_number, input ready);
    modport sink   (input valid, input report_kind, input balanced,
                    input line_number, output ready);
endinterface

// File: design/brkbal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module brkbal_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/bracket_balance_checker_core.sv
// Bracket balance checker: scanner, bracket stack and report queue.
//
// Usage: text bytes enter on i_in, one word per byte, with end_of_text
// set on a closing word whose byte is ignored. Each newline in normal
// text yields a line report on o_out (report_kind 0); the closing word
// yields the whole-text verdict (report_kind 1), after which every
// counter and mode returns to its reset value for the next text.
// Strings and comments are skipped and may span lines.
// Throughput is one byte per cycle while the report queue has room:
// the open brackets of the current line sit in a RAM with the top
// entry held in a register, and the RAM read port always fetches the
// entry just below the top, so a pop has its new top at hand in the
// next cycle. Each report is registered in the queue that feeds o_out.
// Reports pass through a two-word queue, so input is still taken while
// one report waits; i_in.ready drops only when both slots are full.
// Reset (i_rst_n low, synchronous) empties the queue and clears the
// scanner state; the RAM contents are not cleared and need not be.
module bracket_balance_checker_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    brkbal_in_if.sink          i_in,
    brkbal_out_if.source       o_out
);
    import brkbal_pkg::*;

    t_mode                 r_mode, n_mode;
    logic [1:0]            r_mc, n_mc;
    t_mark                 r_fm, n_fm;
    logic                  r_err, n_err;
    logic [STK_CW-1:0]     r_cnt, n_cnt;
    t_kind                 r_top, n_top;
    logic [COUNT_BITS-1:0] r_curly, n_curly;
    logic                  r_text_ok, n_text_ok;
    logic [COUNT_BITS-1:0] r_nl, n_nl;

    t_result               r_q [2];
    logic                  r_wr_ptr, r_rd_ptr;
    logic [1:0]            r_q_cnt;

    logic                  acc, pop;
    logic                  res_valid;
    t_result               res;
    logic                  ram_we;
    logic [STK_AW-1:0]     ram_waddr, ram_raddr;
    logic [1:0]            ram_wdata, ram_rdata;

    assign acc = i_in.valid && i_in.ready;
    assign pop = o_out.valid && o_out.ready;
    assign i_in.ready = (r_q_cnt != 2'd2);

    brkbal_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The read port follows the entry below the next top of stack.
    assign ram_raddr = STK_AW'(n_cnt - STK_CW'(2));

    function automatic logic [LINE_BITS-1:0] f_line_out(logic [COUNT_BITS-1:0] v);
        if (33'(v) > 33'(LINE_OUT_MAX)) begin
            return LINE_BITS'(LINE_OUT_MAX);
        end
        return LINE_BITS'(v);
    endfunction

    always_comb begin
        logic  cont;
        logic  judge;
        logic  line_ok;
        logic  add_mark;
        t_mark mark_code;
        logic  do_push;
        logic  do_pop;
        t_kind kind;
        logic  eot;
        logic [7:0] c;

        n_mode    = r_mode;
        n_mc      = r_mc;
        n_fm      = r_fm;
        n_err     = r_err;
        n_cnt     = r_cnt;
        n_top     = r_top;
        n_curly   = r_curly;
        n_text_ok = r_text_ok;
        n_nl      = r_nl;
        res_valid = 1'b0;
        res       = '0;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[STK_AW-1:0];
        ram_wdata = r_top;
        cont      = 1'b0;
        judge     = 1'b0;
        line_ok   = 1'b0;
        add_mark  = 1'b0;
        mark_code = MARK_OTHER;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        kind      = KIND_PAREN;
        eot       = i_in.end_of_text;
        c         = i_in.ch;

        if (acc) begin
            if (eot) begin
                if (r_mode == MODE_SLASH || r_mode == MODE_STRING ||
                    r_mode == MODE_COMMENT || r_mode == MODE_STAR) begin
                    if (n_mc == 2'd0) n_fm = MARK_OTHER;
                    if (n_mc != 2'd2) n_mc = n_mc + 2'd1;
                end
                judge = 1'b1;
            end else begin
                unique case (r_mode)
                    MODE_STRING: begin
                        if (c == CH_QUOTE) begin
                            if (n_mc == 2'd0) n_fm = MARK_OTHER;
                            if (n_mc != 2'd2) n_mc = n_mc + 2'd1;
                            n_mode = MODE_NORMAL;
                        end else if (c == CH_NEWLINE && n_nl != '1) begin
                            n_nl = n_nl + 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (c == CH_STAR) begin
                            n_mode = MODE_STAR;
                        end else if (c == CH_NEWLINE && n_nl != '1) begin
                            n_nl = n_nl + 1'b1;
                        end
                    end
                    MODE_STAR: begin
                        if (c == CH_SLASH) begin
                            if (n_mc == 2'd0) n_fm = MARK_OTHER;
                            if (n_mc != 2'd2) n_mc = n_mc + 2'd1;
                            n_mode = MODE_NORMAL;
                        end else if (c != CH_STAR) begin
                            if (c == CH_NEWLINE && n_nl != '1) n_nl = n_nl + 1'b1;
                            n_mode = MODE_COMMENT;
                        end
                    end
                    MODE_SLASH: begin
                        if (c == CH_STAR) begin
                            n_mode = MODE_COMMENT;
                        end else begin
                            // A lone slash is a mark; this byte is then plain text.
                            if (n_mc == 2'd0) n_fm = MARK_OTHER;
                            if (n_mc != 2'd2) n_mc = n_mc + 2'd1;
                            n_mode = MODE_NORMAL;
                            cont   = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = MODE_NORMAL;
                        cont   = 1'b1;
                    end
                endcase

                if (cont) begin
                    if (c == CH_NEWLINE) begin
                        if (n_nl != '1) n_nl = n_nl + 1'b1;
                        judge = 1'b1;
                    end else if (c == CH_QUOTE) begin
                        n_mode = MODE_STRING;
                    end else if (c == CH_SLASH) begin
                        n_mode = MODE_SLASH;
                    end else if (c != CH_SPACE && c != CH_TAB) begin
                        add_mark = 1'b1;
                        priority if (c == CH_LCURLY) mark_code = MARK_OPEN_CURLY;
                        else if (c == CH_RCURLY)     mark_code = MARK_CLOSE_CURLY;
                        else                         mark_code = MARK_OTHER;
                        priority if (c == CH_LPAREN) begin
                            do_push = 1'b1; kind = KIND_PAREN;
                        end else if (c == CH_LSQUARE) begin
                            do_push = 1'b1; kind = KIND_SQUARE;
                        end else if (c == CH_LCURLY) begin
                            do_push = 1'b1; kind = KIND_CURLY;
                        end else if (c == CH_RPAREN) begin
                            do_pop = 1'b1; kind = KIND_PAREN;
                        end else if (c == CH_RSQUARE) begin
                            do_pop = 1'b1; kind = KIND_SQUARE;
                        end else if (c == CH_RCURLY) begin
                            do_pop = 1'b1; kind = KIND_CURLY;
                        end
                    end
                end
            end

            if (add_mark) begin
                if (n_mc == 2'd0) n_fm = mark_code;
                if (n_mc != 2'd2) n_mc = n_mc + 2'd1;
            end

            // The top is also kept in a register; a push writes the new entry
            // into the RAM as well.
            if (do_push) begin
                if (32'(r_cnt) < STACK_DEPTH) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt[STK_AW-1:0];
                    ram_wdata = kind;
                    n_cnt     = r_cnt + 1'b1;
                    n_top     = kind;
                end else begin
                    n_err = 1'b1;
                end
            end
            if (do_pop) begin
                if (r_cnt != '0 && r_top == kind) begin
                    n_cnt = r_cnt - 1'b1;
                    n_top = t_kind'(ram_rdata);
                end else begin
                    n_err = 1'b1;
                end
            end

            if (judge) begin
                line_ok = !n_err && (n_cnt == '0);
                if (!line_ok) begin
                    if (n_mc == 2'd1 && n_fm == MARK_OPEN_CURLY) begin
                        if (n_curly != '1) n_curly = n_curly + 1'b1;
                    end else if (n_mc == 2'd1 && n_fm == MARK_CLOSE_CURLY &&
                                 n_curly != '0) begin
                        n_curly = n_curly - 1'b1;
                    end else begin
                        n_text_ok = 1'b0;
                    end
                end
                n_cnt = '0;
                n_err = 1'b0;
                n_mc  = 2'd0;
                n_fm  = MARK_OTHER;
                res_valid       = 1'b1;
                res.line_number = f_line_out(n_nl);
                if (eot) begin
                    res.report_kind = REPORT_FINAL;
                    res.balanced    = n_text_ok && (n_curly == '0);
                    n_mode    = MODE_NORMAL;
                    n_curly   = '0;
                    n_text_ok = 1'b1;
                    n_nl      = '0;
                end else begin
                    res.report_kind = REPORT_LINE;
                    res.balanced    = line_ok;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_mc      <= 2'd0;
            r_fm      <= MARK_OTHER;
            r_err     <= 1'b0;
            r_cnt     <= '0;
            r_top     <= KIND_PAREN;
            r_curly   <= '0;
            r_text_ok <= 1'b1;
            r_nl      <= '0;
            r_wr_ptr  <= 1'b0;
            r_rd_ptr  <= 1'b0;
            r_q_cnt   <= 2'd0;
        end else begin
            r_mode    <= n_mode;
            r_mc      <= n_mc;
            r_fm      <= n_fm;
            r_err     <= n_err;
            r_cnt     <= n_cnt;
            r_top     <= n_top;
            r_curly   <= n_curly;
            r_text_ok <= n_text_ok;
            r_nl      <= n_nl;
            if (res_valid) r_wr_ptr <= ~r_wr_ptr;
            if (pop)       r_rd_ptr <= ~r_rd_ptr;
            r_q_cnt <= r_q_cnt + 2'(res_valid) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    assign o_out.valid       = (r_q_cnt != 2'd0);
    assign o_out.report_kind = r_q[r_rd_ptr].report_kind;
    assign o_out.balanced    = r_q[r_rd_ptr].balanced;
    assign o_out.line_number = r_q[r_rd_ptr].line_number;

`ifndef SYNTH
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= STACK_DEPTH)
        else $error("bracket stack count beyond its depth");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("report queue holds more than two words");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.end_of_text) |=> (r_mode == MODE_NORMAL && r_cnt == '0 &&
                                       r_nl == '0 && r_curly == '0 && r_text_ok))
        else $error("state not cleared after end of text");

    a_eot_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.end_of_text) |=> (r_q_cnt == $past(r_q_cnt) + 2'd1 - 2'($past(pop))))
        else $error("end of text produced no verdict");
`endif

endmodule
